@@ sv/pms_pkg.sv @@
// shared types, kind codes and constants for the particle motion step
// no dependencies; imported by every module of the block
package pms_pkg;

   typedef logic signed [23:0] pos_type;
   typedef logic signed [15:0] spd_type;
   typedef logic [7:0]         byte_type;
   typedef logic [2:0]         kind_code_type;

   typedef enum logic [2:0] {
      KIND_EMPTY     = 3'd0,
      KIND_TELEPORT  = 3'd1,
      KIND_UNUSED    = 3'd2,
      KIND_SNOW      = 3'd3,
      KIND_TRAIL_ONE = 3'd4,
      KIND_TRAIL_TWO = 3'd5,
      KIND_RESPAWN   = 3'd6
   } kind_type;

   localparam spd_type  TELE_DZ_GAIN = 16'sh0080;
   localparam byte_type TELE_AGE_MAX = 8'h1e;
   localparam spd_type  RESP_STEER   = 16'sh0040;
   localparam byte_type RESP_AGE_MAX = 8'h14;

   // one particle record
   typedef struct packed {
      kind_code_type kind;
      pos_type       x;
      pos_type       y;
      pos_type       z;
      spd_type       dx;
      spd_type       dy;
      spd_type       dz;
      byte_type      age;
      byte_type      trail;
   } rec_type;

   // record plus respawn target, as taken from the request side
   typedef struct packed {
      rec_type rec;
      pos_type aim_x;
      pos_type aim_y;
      pos_type aim_z;
   } req_type;

   // position plus sign-extended speed, wrapping at 24 bits
   function automatic pos_type pos_add(input pos_type p, input spd_type s);
      return p + pos_type'({{8{s[15]}}, s});
   endfunction

   function automatic pos_type clamp0(input pos_type p);
      return p[23] ? '0 : p;
   endfunction

endpackage

@@ sv/pms_axis.sv @@
// respawn steering and target approach for one axis
// depends on pms_pkg
module pms_axis (
   input  pms_pkg::pos_type pos,
   input  pms_pkg::pos_type aim,
   input  pms_pkg::spd_type spd,
   output pms_pkg::spd_type spd_out,
   output pms_pkg::pos_type pos_out
);
   import pms_pkg::*;

   logic    below;
   logic    above;
   pos_type moved;

   always_comb begin
      below   = pos < aim;
      above   = aim < pos;
      spd_out = below ? spd + RESP_STEER : spd - RESP_STEER;
      moved   = pos_add(pos, spd_out);
      // no overshoot past the target on either side
      priority if (below) begin
         pos_out = (aim < moved) ? aim : moved;
      end else if (above) begin
         pos_out = (moved < aim) ? aim : moved;
      end else begin
         pos_out = pos;
      end
   end

endmodule

@@ sv/pms_update.sv @@
// combinational tick update of one particle record, per kind
// depends on pms_pkg and pms_axis
module pms_update (
   input  pms_pkg::req_type req,
   output pms_pkg::rec_type res
);
   import pms_pkg::*;

   rec_type  r;
   spd_type  rsp_dx, rsp_dy, rsp_dz;
   pos_type  rsp_x, rsp_y, rsp_z;
   spd_type  tele_dz;
   byte_type age_inc;
   byte_type age_dec;
   byte_type trail_dec;

   assign r = req.rec;

   pms_axis u_axis_x (.pos(r.x), .aim(req.aim_x), .spd(r.dx), .spd_out(rsp_dx), .pos_out(rsp_x));
   pms_axis u_axis_y (.pos(r.y), .aim(req.aim_y), .spd(r.dy), .spd_out(rsp_dy), .pos_out(rsp_y));
   pms_axis u_axis_z (.pos(r.z), .aim(req.aim_z), .spd(r.dz), .spd_out(rsp_dz), .pos_out(rsp_z));

   always_comb begin
      tele_dz   = r.dz + TELE_DZ_GAIN;
      age_inc   = r.age + 8'd1;
      age_dec   = r.age - 8'd1;
      trail_dec = r.trail - 8'd1;
      res       = r;
      unique case (r.kind)
         KIND_TELEPORT: begin
            res.dz  = tele_dz;
            res.x   = pos_add(r.x, r.dx);
            res.y   = pos_add(r.y, r.dy);
            res.z   = clamp0(pos_add(r.z, tele_dz));
            res.age = age_inc;
            if (age_inc > TELE_AGE_MAX) res.kind = KIND_EMPTY;
         end
         KIND_SNOW: begin
            res.x   = pos_add(r.x, r.dx);
            res.y   = pos_add(r.y, r.dy);
            res.age = age_dec;
            if (age_dec == 8'd0) res.kind = KIND_EMPTY;
         end
         KIND_TRAIL_ONE, KIND_TRAIL_TWO: begin
            res.trail = trail_dec;
            if (trail_dec == 8'd0) res.kind = KIND_EMPTY;
         end
         KIND_RESPAWN: begin
            res.dx  = rsp_dx;
            res.dy  = rsp_dy;
            res.dz  = rsp_dz;
            res.x   = rsp_x;
            res.y   = rsp_y;
            res.z   = clamp0(rsp_z);
            res.age = age_inc;
            if (age_inc > RESP_AGE_MAX) res.kind = KIND_EMPTY;
         end
         // empty, unused and the undefined code pass through
         default: res = r;
      endcase
   end

endmodule

@@ sv/particle_motion_step.sv @@
// top level of the particle motion step: input register, update logic, result register
// depends on pms_pkg and pms_update
//
// usage:
//   one particle record per request word (kind, position, speed, respawn target,
//   age and trail life); one updated record per response word, in order.
//   a word moves when valid is high and stall is low on its channel.
// path: an accepted request word is held in the input register, then its updated record in the
//   result register, which drives response valid. throughput: one word per cycle while rsp_stall
//   is low; the update is one pass of combinational logic between the input register and the
//   result register, its longest path being the respawn compare, steer add and approach compare.
// stall: rsp_stall holds the result register; the input register still fills if it is empty,
//   so at most one more request is taken before req_stall rises.
// reset: both stages empty, rsp_valid low; the data registers themselves are not reset.
module particle_motion_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_in_kind,
   input  logic signed [23:0] req_in_x,
   input  logic signed [23:0] req_in_y,
   input  logic signed [23:0] req_in_z,
   input  logic signed [15:0] req_in_dx,
   input  logic signed [15:0] req_in_dy,
   input  logic signed [15:0] req_in_dz,
   input  logic signed [23:0] req_aim_x,
   input  logic signed [23:0] req_aim_y,
   input  logic signed [23:0] req_aim_z,
   input  logic [7:0]       req_in_age,
   input  logic [7:0]       req_in_trail_life,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_new_kind,
   output logic signed [23:0] rsp_new_x,
   output logic signed [23:0] rsp_new_y,
   output logic signed [23:0] rsp_new_z,
   output logic signed [15:0] rsp_new_dx,
   output logic signed [15:0] rsp_new_dy,
   output logic signed [15:0] rsp_new_dz,
   output logic [7:0]       rsp_new_age,
   output logic [7:0]       rsp_new_trail_life
);
   import pms_pkg::*;

   req_type req_word;
   req_type s1_ff, s1_in;
   logic    s1_valid_ff, s1_valid_in;
   rec_type s2_ff, s2_in;
   logic    s2_valid_ff, s2_valid_in;
   rec_type upd;
   logic    s2_ready;
   logic    s1_ready;

   always_comb begin
      req_word.rec.kind  = req_in_kind;
      req_word.rec.x     = req_in_x;
      req_word.rec.y     = req_in_y;
      req_word.rec.z     = req_in_z;
      req_word.rec.dx    = req_in_dx;
      req_word.rec.dy    = req_in_dy;
      req_word.rec.dz    = req_in_dz;
      req_word.rec.age   = req_in_age;
      req_word.rec.trail = req_in_trail_life;
      req_word.aim_x     = req_aim_x;
      req_word.aim_y     = req_aim_y;
      req_word.aim_z     = req_aim_z;
   end

   pms_update u_update (.req(s1_ff), .res(upd));

   always_comb begin
      s2_ready    = !s2_valid_ff || !rsp_stall;
      s1_ready    = !s1_valid_ff || s2_ready;
      req_stall   = !s1_ready;
      s1_in       = (req_valid && s1_ready) ? req_word : s1_ff;
      s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
      s2_in       = (s1_valid_ff && s2_ready) ? upd : s2_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign rsp_valid          = s2_valid_ff;
   assign rsp_new_kind       = s2_ff.kind;
   assign rsp_new_x          = s2_ff.x;
   assign rsp_new_y          = s2_ff.y;
   assign rsp_new_z          = s2_ff.z;
   assign rsp_new_dx         = s2_ff.dx;
   assign rsp_new_dy         = s2_ff.dy;
   assign rsp_new_dz         = s2_ff.dz;
   assign rsp_new_age        = s2_ff.age;
   assign rsp_new_trail_life = s2_ff.trail;

endmodule

@@ sv/pms_checker.sv @@
// port-level checks for particle_motion_step, attached by bind
// depends on pms_pkg and the top level's ports
module pms_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [2:0]        rsp_new_kind,
   input logic signed [23:0] rsp_new_z,
   input logic [7:0]        rsp_new_age,
   input logic [7:0]        rsp_new_trail_life
);
   import pms_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_kind) && $stable(rsp_new_z)
         && $stable(rsp_new_age) && $stable(rsp_new_trail_life))
      else $error("stalled response word changed");

   // an accepted word is shown as a response if the receiver is not stalling once it sits in the input register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing after accepted request");

   // surviving movers never sit below ground or past their age limit
   a_tele_alive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_kind == KIND_TELEPORT |-> !rsp_new_z[23] && rsp_new_age <= TELE_AGE_MAX)
      else $error("teleport survivor out of range");

   a_resp_alive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_kind == KIND_RESPAWN |-> !rsp_new_z[23] && rsp_new_age <= RESP_AGE_MAX)
      else $error("respawn survivor out of range");

   // a living trail never shows an exhausted counter
   a_trail_alive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_new_kind == KIND_TRAIL_ONE || rsp_new_kind == KIND_TRAIL_TWO)
         |-> rsp_new_trail_life != 8'd0)
      else $error("trail survivor with zero life");

endmodule

bind particle_motion_step pms_checker u_pms_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_new_kind(rsp_new_kind),
   .rsp_new_z(rsp_new_z),
   .rsp_new_age(rsp_new_age),
   .rsp_new_trail_life(rsp_new_trail_life)
);
